// File: rtl/bfm_pkg.sv
// Shared constants and types for the battery fault monitor.
`default_nettype none

package bfm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 17;
  localparam int AGE_W    = 32;
  localparam int FAULT_W  = 10;
  localparam int MV_W     = 16;
  localparam int TEMP_W   = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int SPREAD_W = 12;

  typedef logic [FAULT_W-1:0] fault_t;
  typedef logic [1:0]         op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Sample kinds
  localparam op_t OP_VOLT = 2'd0;
  localparam op_t OP_TEMP = 2'd1;
  localparam op_t OP_CURR = 2'd2;

  // Register indexes
  localparam cfg_idx_t REG_VOLT_OVER    = 3'd0;
  localparam cfg_idx_t REG_VOLT_UNDER   = 3'd1;
  localparam cfg_idx_t REG_CHARGE       = 3'd2;
  localparam cfg_idx_t REG_DISCHARGE    = 3'd3;
  localparam cfg_idx_t REG_TEMP_HIGH    = 3'd4;
  localparam cfg_idx_t REG_TEMP_SPREAD  = 3'd5;
  localparam cfg_idx_t REG_STALE_TIMEOUT = 3'd6;

  // Fault bit positions
  localparam int FB_STALE  = 0;
  localparam int FB_COV    = 1;
  localparam int FB_WOV    = 2;
  localparam int FB_CUV    = 3;
  localparam int FB_WUV    = 4;
  localparam int FB_COC    = 5;
  localparam int FB_WOC    = 6;
  localparam int FB_COT    = 7;
  localparam int FB_WOT    = 8;
  localparam int FB_SPREAD = 9;

  // Running value start points
  localparam logic [MV_W-1:0]          VMAX_START = 16'd0;
  localparam logic [MV_W-1:0]          VMIN_START = 16'd5000;
  localparam logic signed [TEMP_W-1:0] TMAX_START = -16'sd1000;
  localparam logic signed [TEMP_W-1:0] TMIN_START = 16'sd1000;

endpackage

`default_nettype wire

// File: rtl/battery_fault_monitor.sv
// Battery fault monitor: threshold, stale and spread checks over a pass of samples.
//
// Takes one request per clock when not stalled. Each request is a cell voltage,
// temperature or pack current sample that passes through an input register and
// one stage of compare and running max/min logic, so the block sustains one
// request per cycle; a pass result is loaded into the result register when its
// last request leaves the input register. Only a request that ends a pass can wait:
// it stays in the input register, and stalls the input, while the previous
// result is still held by a result stall. The only loop is the running state
// (pass faults, latched word, voltage and temperature extremes), updated in that
// single stage whenever a request advances. Configuration registers are written
// through the plain write port only while idle; the user, not the block, ensures it.
`default_nettype none

module battery_fault_monitor #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_write_en,
  input  wire  [bfm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [bfm_pkg::CFG_W-1:0]             cfg_data,
  // request channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [1:0]                            in_operation,
  input  wire  signed [bfm_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire  [bfm_pkg::AGE_W-1:0]             in_age_ms,
  input  wire                                   in_clear_request,
  input  wire                                   in_last_of_pass,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [bfm_pkg::FAULT_W-1:0]           out_pass_faults,
  output logic [bfm_pkg::FAULT_W-1:0]           out_latched_faults,
  output logic [bfm_pkg::MV_W-1:0]              out_cell_max_mv,
  output logic [bfm_pkg::MV_W-1:0]              out_cell_min_mv
);

  // Compare width covers the sample and the 16-bit limits with sign room
  localparam int CW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
  localparam logic signed [CW-1:0] V_SAT  = CW'(65535);
  localparam logic signed [CW-1:0] T_HI   = CW'(32767);
  localparam logic signed [CW-1:0] T_LO   = -(CW'(32768));

  // Configuration registers
  logic [31:0]                     volt_over_r, volt_under_r, charge_r, discharge_r;
  logic [31:0]                     temp_high_r, stale_r;
  logic [bfm_pkg::SPREAD_W-1:0]    spread_lim_r;

  // Input stage
  logic                            s1_valid_r;
  bfm_pkg::op_t                    s1_op_r;
  logic [bfm_pkg::SAMPLE_W-1:0]    s1_sample_r;
  logic [bfm_pkg::AGE_W-1:0]       s1_age_r;
  logic                            s1_clear_r, s1_last_r;

  // Running state
  bfm_pkg::fault_t                 pend_r, pend_nxt;
  bfm_pkg::fault_t                 latch_r, latch_nxt;
  logic [bfm_pkg::MV_W-1:0]        vmax_r, vmax_nxt, vmin_r, vmin_nxt;
  logic signed [bfm_pkg::TEMP_W-1:0] tmax_r, tmax_nxt, tmin_r, tmin_nxt;

  // Result register
  logic                            out_valid_r;
  bfm_pkg::fault_t                 out_pass_r, out_latch_r;
  logic [bfm_pkg::MV_W-1:0]        out_vmax_r, out_vmin_r;

  logic                            s1_adv, in_take, out_load;
  logic [SAMPLE_BITS-1:0]          raw;
  logic signed [CW-1:0]            volt_c, samp_c;
  logic [bfm_pkg::MV_W-1:0]        vs16;
  logic signed [bfm_pkg::TEMP_W-1:0] ts16;
  logic signed [CW-1:0]            ov_crit, ov_warn, uv_crit, uv_warn;
  logic signed [CW-1:0]            ch_crit, ch_warn, dis_crit, dis_warn, ot_crit, ot_warn;
  logic                            stale;
  bfm_pkg::fault_t                 item_f, pass_f;
  logic signed [bfm_pkg::TEMP_W:0] spread;

  // Handshake: an item without a result always moves on
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign out_load = s1_adv && s1_last_r;

  // Take the low SAMPLE_BITS bits of the sample, zero above the field
  for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_raw
    if (i < bfm_pkg::SAMPLE_W) begin : g_bit
      assign raw[i] = s1_sample_r[i];
    end else begin : g_zero
      assign raw[i] = 1'b0;
    end
  end

  // Extend sample and limits to the compare width
  assign volt_c  = $signed({{(CW-SAMPLE_BITS){1'b0}}, raw});
  assign samp_c  = $signed({{(CW-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw});
  assign ov_crit = $signed({{(CW-16){1'b0}}, volt_over_r[31:16]});
  assign ov_warn = $signed({{(CW-16){1'b0}}, volt_over_r[15:0]});
  assign uv_crit = $signed({{(CW-16){1'b0}}, volt_under_r[31:16]});
  assign uv_warn = $signed({{(CW-16){1'b0}}, volt_under_r[15:0]});
  assign ch_crit  = $signed({{(CW-16){charge_r[31]}}, charge_r[31:16]});
  assign ch_warn  = $signed({{(CW-16){charge_r[15]}}, charge_r[15:0]});
  assign dis_crit = $signed({{(CW-16){discharge_r[31]}}, discharge_r[31:16]});
  assign dis_warn = $signed({{(CW-16){discharge_r[15]}}, discharge_r[15:0]});
  assign ot_crit  = $signed({{(CW-16){temp_high_r[31]}}, temp_high_r[31:16]});
  assign ot_warn  = $signed({{(CW-16){temp_high_r[15]}}, temp_high_r[15:0]});

  // Saturate values for the running extremes
  assign vs16 = (volt_c > V_SAT) ? 16'hFFFF : volt_c[15:0];
  always_comb begin
    if (samp_c > T_HI) begin
      ts16 = 16'sh7FFF;
    end else if (samp_c < T_LO) begin
      ts16 = -16'sh8000;
    end else begin
      ts16 = samp_c[15:0];
    end
  end

  assign stale = s1_age_r > stale_r;

  // Check the item and update running values
  always_comb begin
    item_f   = '0;
    vmax_nxt = vmax_r;
    vmin_nxt = vmin_r;
    tmax_nxt = tmax_r;
    tmin_nxt = tmin_r;
    case (s1_op_r)
      bfm_pkg::OP_VOLT: begin
        item_f[bfm_pkg::FB_STALE] = stale;
        if (vs16 > vmax_r) vmax_nxt = vs16;
        if (vs16 < vmin_r) vmin_nxt = vs16;
        if (volt_c > ov_crit) item_f[bfm_pkg::FB_COV] = 1'b1;
        else if (volt_c > ov_warn) item_f[bfm_pkg::FB_WOV] = 1'b1;
        if (volt_c < uv_crit) item_f[bfm_pkg::FB_CUV] = 1'b1;
        else if (volt_c < uv_warn) item_f[bfm_pkg::FB_WUV] = 1'b1;
      end
      bfm_pkg::OP_TEMP: begin
        item_f[bfm_pkg::FB_STALE] = stale;
        if (ts16 > tmax_r) tmax_nxt = ts16;
        if (ts16 < tmin_r) tmin_nxt = ts16;
        if (samp_c > ot_crit) item_f[bfm_pkg::FB_COT] = 1'b1;
        else if (samp_c > ot_warn) item_f[bfm_pkg::FB_WOT] = 1'b1;
      end
      bfm_pkg::OP_CURR: begin
        if (samp_c > ch_crit || samp_c < dis_crit) item_f[bfm_pkg::FB_COC] = 1'b1;
        else if (samp_c > ch_warn || samp_c < dis_warn) item_f[bfm_pkg::FB_WOC] = 1'b1;
      end
      default: begin
        item_f = '0;
      end
    endcase
  end

  // Close the pass: spread check, then merge into the latched word
  assign spread = {tmax_nxt[15], tmax_nxt} - {tmin_nxt[15], tmin_nxt};
  always_comb begin
    pass_f = pend_r | item_f;
    if (spread > $signed({5'b0, spread_lim_r})) begin
      pass_f[bfm_pkg::FB_SPREAD] = 1'b1;
    end
    pend_nxt  = pend_r | item_f;
    latch_nxt = s1_clear_r ? '0 : latch_r;
    if (s1_last_r) begin
      latch_nxt = latch_nxt | pass_f;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_over_r  <= '0;
      volt_under_r <= '0;
      charge_r     <= '0;
      discharge_r  <= '0;
      temp_high_r  <= '0;
      spread_lim_r <= '0;
      stale_r      <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bfm_pkg::REG_VOLT_OVER:     volt_over_r  <= cfg_data;
        bfm_pkg::REG_VOLT_UNDER:    volt_under_r <= cfg_data;
        bfm_pkg::REG_CHARGE:        charge_r     <= cfg_data;
        bfm_pkg::REG_DISCHARGE:     discharge_r  <= cfg_data;
        bfm_pkg::REG_TEMP_HIGH:     temp_high_r  <= cfg_data;
        bfm_pkg::REG_TEMP_SPREAD:   spread_lim_r <= cfg_data[bfm_pkg::SPREAD_W-1:0];
        bfm_pkg::REG_STALE_TIMEOUT: stale_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted request in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r     <= in_operation;
      s1_sample_r <= in_sample;
      s1_age_r    <= in_age_ms;
      s1_clear_r  <= in_clear_request;
      s1_last_r   <= in_last_of_pass;
    end
  end

  // Advance running state; restart it at the end of a pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      latch_r <= '0;
      vmax_r  <= bfm_pkg::VMAX_START;
      vmin_r  <= bfm_pkg::VMIN_START;
      tmax_r  <= bfm_pkg::TMAX_START;
      tmin_r  <= bfm_pkg::TMIN_START;
    end else if (s1_adv) begin
      latch_r <= latch_nxt;
      if (s1_last_r) begin
        pend_r <= '0;
        vmax_r <= bfm_pkg::VMAX_START;
        vmin_r <= bfm_pkg::VMIN_START;
        tmax_r <= bfm_pkg::TMAX_START;
        tmin_r <= bfm_pkg::TMIN_START;
      end else begin
        pend_r <= pend_nxt;
        vmax_r <= vmax_nxt;
        vmin_r <= vmin_nxt;
        tmax_r <= tmax_nxt;
        tmin_r <= tmin_nxt;
      end
    end
  end

  // Result register: load on end of pass, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pass_r  <= pass_f;
      out_latch_r <= latch_nxt;
      out_vmax_r  <= vmax_nxt;
      out_vmin_r  <= vmin_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pass_faults    = out_pass_r;
  assign out_latched_faults = out_latch_r;
  assign out_cell_max_mv    = out_vmax_r;
  assign out_cell_min_mv    = out_vmin_r;

endmodule

`default_nettype wire
